// ===== sv/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
`default_nettype none

package tcce_pkg;

  // Command codes carried on the command field
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

  // Control characters with special handling
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Attribute after reset: light grey on black
  localparam logic [7:0] RESET_ATTR = 8'h07;

  // Tab stops fall on multiples of this
  localparam int unsigned TAB_STEP = 4;

endpackage

`default_nettype wire

// ===== sv/text_console_cursor_engine.sv =====
// Text console: screen cell memory, cursor tracking and command sequencer.
`default_nettype none

// Keeps a COLUMNS x ROWS screen of 16-bit cells (attribute high byte, character
// low byte) in one synchronous memory with one write and one read port, plus
// a cursor. One command is in flight at a time. Set cursor, carriage return,
// newline, tab, backspace and printable characters go from the accepted beat
// straight to the DONE state, which loads the result beat; read cell passes
// through the READ state first because the memory read port is registered.
// Clear screen writes one cell per cycle through the FILL state. A put that
// runs past the last row scrolls: every cell is copied or blanked once
// through the memory ports in the SCROLL and BLANK states. After reset a
// clearing pass fills the screen with spaces in attribute 7, during which
// no command is taken; attribute writes are taken at any time. A result beat
// waits in an output register, so a stalled output does not block the next
// command from being accepted.
module text_console_cursor_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // attribute register
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [6:0]  column_i,
  input  wire logic [4:0]  row_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       cursor_column_o,
  output logic [4:0]       cursor_row_o,
  output logic [10:0]      cursor_linear_o,
  output logic [15:0]      cell_data_o
);

  import tcce_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned COPY_N = COLUMNS * (ROWS - 1);
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned CW     = $clog2(COLUMNS);
  localparam int unsigned RW     = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END   = AW'(COPY_N);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
  localparam logic [CW:0]   COL_LIMIT  = (CW+1)'(COLUMNS);
  localparam logic [RW:0]   ROW_LIMIT  = (RW+1)'(ROWS);
  localparam logic [CW-1:0] COL_MAX    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_MAX    = RW'(ROWS - 1);
  localparam logic [CW:0]   TAB_ADD    = (CW+1)'(TAB_STEP);
  localparam logic [CW:0]   TAB_MASK   = ~((CW+1)'(TAB_STEP - 1));

  // Registers
  state_e          state_q, state_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [7:0]      attr_q;
  logic [AW-1:0]   scan_q, scan_d;
  logic [15:0]     fill_data_q, fill_data_d;
  logic            fill_init_q, fill_init_d;
  logic [15:0]     cell_q, cell_d;
  logic            out_valid_q;
  logic [6:0]      out_col_q;
  logic [4:0]      out_row_q;
  logic [10:0]     out_lin_q;
  logic [15:0]     out_cell_q;

  // Screen memory
  logic [15:0]     mem_q [CELLS];
  logic [15:0]     rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;

  // Combinational helpers
  logic            in_accept;
  logic            out_load;
  cmd_e            cmd;
  logic [AW-1:0]   cur_lin;
  logic [CW-1:0]   sat_col;
  logic [RW-1:0]   sat_row;
  logic [AW-1:0]   sat_lin;
  logic [CW:0]     put_col;
  logic [RW:0]     put_row;
  logic            put_we;
  logic [AW-1:0]   put_addr;
  logic [15:0]     put_data;
  logic [15:0]     blank;
  logic            scroll_done;
  logic            scan_last;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign cmd         = cmd_e'(command_i);
  assign blank       = {attr_q, CH_SPACE};
  assign scroll_done = (scan_q == COPY_END);
  assign scan_last   = (scan_q == LAST_CELL);

  // Linear cell index of the cursor and of the requested cell
  assign cur_lin = AW'(AW'(row_q) * ROW_STRIDE) + AW'(col_q);
  assign sat_col = ({1'b0, column_i} > 8'(COLUMNS - 1)) ? COL_MAX : CW'(column_i);
  assign sat_row = ({1'b0, row_i} > 6'(ROWS - 1)) ? ROW_MAX : RW'(row_i);
  assign sat_lin = AW'(AW'(sat_row) * ROW_STRIDE) + AW'(sat_col);

  // Cursor movement and cell write for a put command
  always_comb begin
    logic [CW:0] col_inc;
    logic [CW:0] col_tab;
    col_inc  = {1'b0, col_q} + (CW+1)'(1);
    col_tab  = ({1'b0, col_q} + TAB_ADD) & TAB_MASK;
    put_col  = {1'b0, col_q};
    put_row  = {1'b0, row_q};
    put_we   = 1'b0;
    put_addr = cur_lin;
    put_data = {attr_q, char_code_i};
    case (char_code_i)
      CH_LF: begin
        put_col = '0;
        put_row = {1'b0, row_q} + (RW+1)'(1);
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_TAB: begin
        if (col_tab >= COL_LIMIT) begin
          put_col = '0;
          put_row = {1'b0, row_q} + (RW+1)'(1);
        end else begin
          put_col = col_tab;
        end
      end
      CH_BS: begin
        if (col_q != '0) begin
          put_col  = {1'b0, col_q} - (CW+1)'(1);
          put_we   = 1'b1;
          put_addr = cur_lin - AW'(1);
          put_data = blank;
        end
      end
      default: begin
        put_we = 1'b1;
        if (col_inc >= COL_LIMIT) begin
          put_col = '0;
          put_row = {1'b0, row_q} + (RW+1)'(1);
        end else begin
          put_col = col_inc;
        end
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (scan_last) begin
          state_d = fill_init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd)
            CMD_PUT:   state_d = (put_row >= ROW_LIMIT) ? ST_SCROLL : ST_DONE;
            CMD_CLEAR: state_d = ST_FILL;
            CMD_SET:   state_d = ST_DONE;
            CMD_READ:  state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_d = ST_DONE;
      ST_SCROLL: begin
        if (scroll_done) begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and memory ports
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    scan_d      = scan_q;
    fill_data_d = fill_data_q;
    fill_init_d = fill_init_q;
    cell_d      = cell_q;
    mem_we      = 1'b0;
    mem_waddr   = scan_q;
    mem_wdata   = fill_data_q;
    mem_raddr   = sat_lin;
    case (state_q)
      ST_FILL: begin
        mem_we = 1'b1;
        scan_d = scan_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_accept) begin
          cell_d = '0;
          scan_d = '0;
          case (cmd)
            CMD_PUT: begin
              mem_we    = put_we;
              mem_waddr = put_addr;
              mem_wdata = put_data;
              col_d     = CW'(put_col);
              row_d     = (put_row >= ROW_LIMIT) ? ROW_MAX : RW'(put_row);
            end
            CMD_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              fill_data_d = blank;
              fill_init_d = 1'b0;
            end
            CMD_SET: begin
              col_d = sat_col;
              row_d = sat_row;
            end
            default: begin
              mem_raddr = sat_lin;
            end
          endcase
        end
      end
      ST_READ: begin
        cell_d = rdata_q;
      end
      ST_SCROLL: begin
        // read one row ahead, write the word read last cycle one cell back;
        // the last copy leaves scan on the first cell of the bottom row
        mem_raddr = scan_q + ROW_STRIDE;
        mem_we    = (scan_q != '0);
        mem_waddr = scan_q - AW'(1);
        mem_wdata = rdata_q;
        scan_d    = scroll_done ? scan_q : scan_q + AW'(1);
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = blank;
        scan_d    = scan_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= RESET_ATTR;
      scan_q      <= '0;
      fill_data_q <= {RESET_ATTR, CH_SPACE};
      fill_init_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      scan_q      <= scan_d;
      fill_data_q <= fill_data_d;
      fill_init_q <= fill_init_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (out_load) begin
      out_col_q  <= 7'(col_q);
      out_row_q  <= 5'(row_q);
      out_lin_q  <= 11'(cur_lin);
      out_cell_q <= cell_q;
    end
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cursor_column_o = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_linear_o = out_lin_q;
  assign cell_data_o     = out_cell_q;

`ifndef SYNTHESIS
  // cursor always points inside the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
    else $error("cursor outside the screen");

  // no write lands outside the cell array
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < CELLS))
    else $error("memory write beyond last cell");

  // a result beat is only raised from the completion state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  // an accepted command always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted command did not start");

  // scrolling keeps the cursor on the last row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCROLL) || (state_q == ST_BLANK)) |-> (row_q == ROW_MAX))
    else $error("scroll with cursor off the last row");
`endif

endmodule

`default_nettype wire
